// File: design/sphere_frustum_cull_core_defines.svh
// Assertion macros shared by the checker of the sphere frustum culling core.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SPHERE_FRUSTUM_CULL_CORE_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SFC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sphere frustum cull core assertion failed");

// Checked on every clock edge, reset included.
`define SFC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("sphere frustum cull core assertion failed");

`endif

// File: design/sfc_pkg.sv
// Shared types and constants of the sphere frustum culling core.
// No dependencies.
`default_nettype none

package sfc_pkg;

    localparam int SPH_W                = 16;
    localparam int MASK_W               = 6;
    localparam int REG_COUNT            = 6;
    localparam int CFG_IDX_W            = 3;
    localparam int PLANE_W              = 64;
    localparam int PROD_W               = 2 * SPH_W;
    localparam int SUM_W                = PROD_W + 4;
    localparam int DEF_PLANE_COUNT      = 6;
    localparam int DEF_NORMAL_FRAC_BITS = 14;

    typedef struct packed {
        logic signed [SPH_W-1:0] cx;
        logic signed [SPH_W-1:0] cy;
        logic signed [SPH_W-1:0] cz;
        logic signed [SPH_W-1:0] r;
    } t_sphere;

    typedef struct packed {
        t_sphere           sphere;
        logic [MASK_W-1:0] mask;
    } t_token;

    typedef struct packed {
        logic signed [SPH_W-1:0] d;
        logic signed [SPH_W-1:0] nz;
        logic signed [SPH_W-1:0] ny;
        logic signed [SPH_W-1:0] nx;
    } t_plane;

endpackage

`default_nettype wire

// File: design/sfc_cell.sv
// One plane of the culling chain: holds its plane register and tests each sphere.
// Two register stages per cell. Depends on sfc_pkg.
`default_nettype none

module sfc_cell
    import sfc_pkg::*;
#(
    parameter int CELL_INDEX       = 0,
    parameter int NORMAL_FRAC_BITS = DEF_NORMAL_FRAC_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire logic [PLANE_W-1:0] i_wr_data,
    input  wire logic               i_valid,
    input  wire t_token             i_tok,
    output logic                    o_valid,
    output t_token                  o_tok
);

    t_plane                    r_plane;
    logic                      r_valid_a;
    t_token                    r_tok_a;
    logic signed [PROD_W-1:0]  r_px;
    logic signed [PROD_W-1:0]  r_py;
    logic signed [PROD_W-1:0]  r_pz;
    logic                      r_valid_b;
    t_token                    r_tok_b;
    t_token                    n_tok_b;
    logic signed [SPH_W:0]     w_dr;
    logic [SUM_W-1:0]          w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_wr_en) begin
            r_plane <= t_plane'(i_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_a <= i_tok;
        r_px    <= PROD_W'(r_plane.nx) * PROD_W'(i_tok.sphere.cx);
        r_py    <= PROD_W'(r_plane.ny) * PROD_W'(i_tok.sphere.cy);
        r_pz    <= PROD_W'(r_plane.nz) * PROD_W'(i_tok.sphere.cz);
        r_tok_b <= n_tok_b;
    end

    // The plane passes when n.c + (d + r) * 2^F is not negative.
    always_comb begin
        w_dr  = {r_plane.d[SPH_W-1], r_plane.d} + {r_tok_a.sphere.r[SPH_W-1], r_tok_a.sphere.r};
        w_sum = {{(SUM_W-PROD_W){r_px[PROD_W-1]}}, r_px}
              + {{(SUM_W-PROD_W){r_py[PROD_W-1]}}, r_py}
              + {{(SUM_W-PROD_W){r_pz[PROD_W-1]}}, r_pz}
              + ({{(SUM_W-SPH_W-1){w_dr[SPH_W]}}, w_dr} << NORMAL_FRAC_BITS);
        n_tok_b = r_tok_a;
        n_tok_b.mask[CELL_INDEX] = w_sum[SUM_W-1];
    end

    assign o_valid = r_valid_b;
    assign o_tok   = r_tok_b;

endmodule

`default_nettype wire

// File: design/sphere_frustum_cull_core.sv
// Top level of the sphere frustum culling core: plane cell chain and result register.
// Depends on sfc_pkg and sfc_cell.
`default_nettype none

// One sphere is taken every clock cycle; busy never rises. Each sphere passes
// through a chain of one cell per tested plane, each cell two register stages, and
// then the result register; its result shows on o_valid for exactly one cycle.
// The receiver cannot stall the block, so results must be taken when shown. The
// user must write plane registers through the configuration port only while no
// sphere is in flight; the block itself does not enforce this.
module sphere_frustum_cull_core
    import sfc_pkg::*;
#(
    parameter int PLANE_COUNT      = DEF_PLANE_COUNT,
    parameter int NORMAL_FRAC_BITS = DEF_NORMAL_FRAC_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic signed [SPH_W-1:0] i_center_x,
    input  wire logic signed [SPH_W-1:0] i_center_y,
    input  wire logic signed [SPH_W-1:0] i_center_z,
    input  wire logic signed [SPH_W-1:0] i_sphere_radius,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [PLANE_W-1:0]      i_cfg_data,
    output logic                         o_valid,
    output logic                         o_visible,
    output logic [MASK_W-1:0]            o_outside_mask,
    output logic                         o_status
);

    localparam int CELL_COUNT = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;

    logic              w_valid [0:CELL_COUNT];
    t_token            w_tok   [0:CELL_COUNT];
    logic              r_valid;
    logic              r_visible;
    logic [MASK_W-1:0] r_mask;
    logic              r_status;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign w_valid[0]         = start;
    assign w_tok[0].sphere.cx = i_center_x;
    assign w_tok[0].sphere.cy = i_center_y;
    assign w_tok[0].sphere.cz = i_center_z;
    assign w_tok[0].sphere.r  = i_sphere_radius;
    assign w_tok[0].mask      = '0;

    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
        sfc_cell #(
            .CELL_INDEX       (g),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (i_cfg_valid && (i_cfg_index == CFG_IDX_W'(g))),
            .i_wr_data (i_cfg_data),
            .i_valid   (w_valid[g]),
            .i_tok     (w_tok[g]),
            .o_valid   (w_valid[g+1]),
            .o_tok     (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_valid[CELL_COUNT];
        end
    end

    always_ff @(posedge i_clk) begin
        r_visible <= (w_tok[CELL_COUNT].mask == '0);
        r_mask    <= w_tok[CELL_COUNT].mask;
        r_status  <= w_tok[CELL_COUNT].sphere.r[SPH_W-1];
    end

    assign o_valid        = r_valid;
    assign o_visible      = r_visible;
    assign o_outside_mask = r_mask;
    assign o_status       = r_status;

endmodule

`default_nettype wire

// File: design/sfc_checker.sv
// Port-level checks of the sphere frustum culling core, bound to the top level.
// Depends on sfc_pkg and sphere_frustum_cull_core_defines.svh.
`default_nettype none
`include "sphere_frustum_cull_core_defines.svh"

module sfc_checker
    import sfc_pkg::*;
#(
    parameter int PLANE_COUNT = DEF_PLANE_COUNT
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic signed [SPH_W-1:0] i_sphere_radius,
    input wire logic                    o_valid,
    input wire logic                    o_visible,
    input wire logic [MASK_W-1:0]       o_outside_mask,
    input wire logic                    o_status
);

    localparam int CELL_COUNT = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;
    localparam int LATENCY    = 2 * CELL_COUNT + 1;

    `SFC_ASSERT_ALWAYS(a_never_busy, !busy)
    `SFC_ASSERT(a_result_follows_start, o_valid |-> $past(start && !busy, LATENCY))
    `SFC_ASSERT(a_visible_matches_mask, o_valid |-> (o_visible == (o_outside_mask == '0)))
    `SFC_ASSERT(a_status_from_radius, o_valid |-> (o_status == $past(i_sphere_radius[SPH_W-1], LATENCY)))
    `SFC_ASSERT(a_untested_planes_clear, o_valid |-> ((o_outside_mask >> CELL_COUNT) == '0))

endmodule

bind sphere_frustum_cull_core sfc_checker #(
    .PLANE_COUNT (PLANE_COUNT)
) u_sfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_sphere_radius (i_sphere_radius),
    .o_valid         (o_valid),
    .o_visible       (o_visible),
    .o_outside_mask  (o_outside_mask),
    .o_status        (o_status)
);

`default_nettype wire
